@@ design/dcrc_pkg.sv @@
package dcrc_pkg;

	localparam int CRC_W  = 32;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 2;

	localparam logic [CRC_W-1:0] POLY_FIRST_RESET  = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0] POLY_SECOND_RESET = 32'h1247_7CDF;

	typedef enum logic [IDX_W-1:0] {
		REG_POLY_FIRST  = 2'd0,
		REG_POLY_SECOND = 2'd1,
		REG_PATH_MODE   = 2'd2
	} reg_idx_t;

	localparam logic [BYTE_W-1:0] CHAR_LC_A  = 8'h61;
	localparam logic [BYTE_W-1:0] CHAR_LC_Z  = 8'h7A;
	localparam logic [BYTE_W-1:0] CHAR_UC_A  = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_BSLSH = 8'h5C;
	localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;

endpackage

@@ design/dcrc_byte_update.sv @@
module dcrc_byte_update (
	input  logic [dcrc_pkg::CRC_W-1:0]  crc,
	input  logic [dcrc_pkg::BYTE_W-1:0] data_byte,
	input  logic [dcrc_pkg::CRC_W-1:0]  poly,
	output logic [dcrc_pkg::CRC_W-1:0]  crc_next
);

	always_comb begin
		logic [dcrc_pkg::CRC_W-1:0] c;
		c = crc ^ {{(dcrc_pkg::CRC_W-dcrc_pkg::BYTE_W){1'b0}}, data_byte};
		for (int k = 0; k < dcrc_pkg::BYTE_W; k++) begin
			c = c[0] ? (poly ^ (c >> 1)) : (c >> 1);
		end
		crc_next = c;
	end

endmodule

@@ design/dual_crc32_path_hash.sv @@
// Two reflected CRC-32 registers, each with its own programmable polynomial, run
// over one byte stream: one byte per beat on s_*, zero initial value, no final XOR.
// With path_mode set, a-z are folded to A-Z and backslash to slash before hashing.
// The beat marked with s_tlast yields one 64-bit digest on m_* (first CRC in bits
// 63:32, second in 31:0) and clears both registers. Throughput is one byte per
// clock, set by the eight-step shift-XOR chain of each CRC in the compute stage;
// a last byte is held in the byte_s1 stage, its digest is then registered in
// digest_q, and that byte waits there while the previous digest is unaccepted.
// Write the configuration registers only while no message is in flight.
module dual_crc32_path_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] digest
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [dcrc_pkg::CRC_W-1:0]  poly_first_q, poly_second_q;
	logic                        path_mode_q;
	logic [dcrc_pkg::CRC_W-1:0]  crc_first_q, crc_second_q;
	logic                        valid_s1, last_s1;
	logic [dcrc_pkg::BYTE_W-1:0] byte_s1, byte_fold;
	logic [dcrc_pkg::CRC_W-1:0]  crc_first_nx, crc_second_nx;
	logic                        advance;
	logic                        out_valid_q;
	logic [63:0]                 digest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_first_q  <= dcrc_pkg::POLY_FIRST_RESET;
			poly_second_q <= dcrc_pkg::POLY_SECOND_RESET;
			path_mode_q   <= 1'b0;
		end else if (cfg_we) begin
			case (dcrc_pkg::reg_idx_t'(cfg_index))
				dcrc_pkg::REG_POLY_FIRST:  poly_first_q  <= cfg_data;
				dcrc_pkg::REG_POLY_SECOND: poly_second_q <= cfg_data;
				dcrc_pkg::REG_PATH_MODE:   path_mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a last beat stalls only while the digest slot is still full
	assign advance  = valid_s1 && !(last_s1 && out_valid_q && !m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		byte_fold = byte_s1;
		if (path_mode_q) begin
			if (byte_s1 >= dcrc_pkg::CHAR_LC_A && byte_s1 <= dcrc_pkg::CHAR_LC_Z) begin
				byte_fold = byte_s1 - dcrc_pkg::CHAR_LC_A + dcrc_pkg::CHAR_UC_A;
			end else if (byte_s1 == dcrc_pkg::CHAR_BSLSH) begin
				byte_fold = dcrc_pkg::CHAR_SLASH;
			end
		end
	end

	dcrc_byte_update u_crc_first (
		.crc       (crc_first_q),
		.data_byte (byte_fold),
		.poly      (poly_first_q),
		.crc_next  (crc_first_nx)
	);

	dcrc_byte_update u_crc_second (
		.crc       (crc_second_q),
		.data_byte (byte_fold),
		.poly      (poly_second_q),
		.crc_next  (crc_second_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_first_q  <= '0;
			crc_second_q <= '0;
		end else if (advance) begin
			crc_first_q  <= last_s1 ? '0 : crc_first_nx;
			crc_second_q <= last_s1 ? '0 : crc_second_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			digest_q <= {crc_first_nx, crc_second_nx};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = digest_q;

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty stage");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> m_tvalid)
		else $error("last beat produced no digest");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (crc_first_q == '0 && crc_second_q == '0))
		else $error("crc registers not cleared after last beat");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid && !(advance && last_s1)) |=> !m_tvalid)
		else $error("digest raised without a last beat");

endmodule
